/* rtl/qts_pkg.sv */
package qts_pkg;

	localparam int MAX_TOKENS = 32;
	localparam int LINE_MAX   = 256;

	localparam int CH_W    = 8;
	localparam int TOKEN_W = 6;
	localparam int INDEX_W = 5;
	localparam int BYTES_W = 9;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CH_W-1:0] CH_BSL   = 8'h5c;

	localparam logic [2:0] ADDR_TOKEN_LIMIT = 3'd0;
	localparam logic [2:0] ADDR_LINE_LIMIT  = 3'd4;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LONG = 2'd1,
		ST_MANY = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		M_BETWEEN    = 7'b0000001,
		M_WORD       = 7'b0000010,
		M_QSTART     = 7'b0000100,
		M_QBODY      = 7'b0001000,
		M_QESC_START = 7'b0010000,
		M_QESC       = 7'b0100000,
		M_SKIP       = 7'b1000000
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [TOKEN_W-1:0] tokens;
		logic [BYTES_W-1:0] bytes;
		status_t            err;
	} scan_state_t;

	typedef struct packed {
		logic               char_valid;
		logic [CH_W-1:0]    out_char;
		logic               token_start;
		logic [INDEX_W-1:0] token_index;
		logic               line_done;
		logic [TOKEN_W-1:0] token_count;
		status_t            status;
	} result_t;

endpackage

/* rtl/quoted_token_splitter_unit.sv */
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] = ch
// m_axis    out  m_axis_tvalid/tready       tdata = result fields, tlast = line_done
// apb       in   psel/penable/pwrite/pready token_limit @0x0, line_limit @0x4
//
// One request per cycle sustained while m_axis accepts; each byte waits in the input register
// (valid_s1/ch_s1), and the qts_scan result, with the mode update, is registered in result_q for m_axis.
// The input register absorbs one request while a result waits on m_axis.
// Reset clears the scan state, both valids and the limits to 32 and 256.
module quoted_token_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] char_valid, [8:1] out_char, [9] token_start,
	                                    // [14:10] token_index, [20:15] token_count,
	                                    // [22:21] status, [23] zero
	output logic        m_axis_tlast,   // line_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qts_pkg::*;

	logic                 valid_s1;
	logic [CH_W-1:0]      ch_s1;
	logic                 out_valid_q;
	result_t              result_q;
	scan_state_t          state_q;
	scan_state_t          state_nxt;
	result_t              result_nxt;
	logic [TOKEN_W-1:0]   token_limit_q;
	logic [BYTES_W-1:0]   line_limit_q;
	logic                 advance;
	logic                 take;
	logic                 cfg_wr;

	assign advance       = !out_valid_q || m_axis_tready;
	assign take          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready;

	qts_scan u_scan (
		.ch          (ch_s1),
		.st          (state_q),
		.token_limit (token_limit_q),
		.line_limit  (line_limit_q),
		.nxt         (state_nxt),
		.res         (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{mode: M_BETWEEN, tokens: '0, bytes: '0, err: ST_OK};
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (take) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
		if (take) begin
			result_q <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_limit_q <= TOKEN_W'(MAX_TOKENS);
			line_limit_q  <= BYTES_W'(LINE_MAX);
		end else if (cfg_wr) begin
			if (paddr[2] == ADDR_LINE_LIMIT[2]) begin
				line_limit_q <= pwdata[BYTES_W-1:0];
			end else begin
				token_limit_q <= pwdata[TOKEN_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == ADDR_LINE_LIMIT[2]) begin
			prdata = {{(32-BYTES_W){1'b0}}, line_limit_q};
		end else begin
			prdata = {{(32-TOKEN_W){1'b0}}, token_limit_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = result_q.line_done;
	assign m_axis_tdata  = {1'b0, result_q.status, result_q.token_count, result_q.token_index,
	                        result_q.token_start, result_q.out_char, result_q.char_valid};

endmodule

/* rtl/qts_scan.sv */
module qts_scan (
	input  logic [qts_pkg::CH_W-1:0]    ch,
	input  qts_pkg::scan_state_t        st,
	input  logic [qts_pkg::TOKEN_W-1:0] token_limit,
	input  logic [qts_pkg::BYTES_W-1:0] line_limit,
	output qts_pkg::scan_state_t        nxt,
	output qts_pkg::result_t            res
);
	import qts_pkg::*;

	logic               blank;
	logic [TOKEN_W-1:0] tl_eff;
	logic [BYTES_W-1:0] ll_eff;
	logic [TOKEN_W-1:0] tok_m1;
	logic [INDEX_W-1:0] idx_cur;
	logic               at_limit;
	mode_t              end_mode;
	status_t            end_err;

	always_comb begin
		blank = (ch == CH_SPACE) || (ch == CH_TAB);
		if (token_limit == '0) begin
			tl_eff = TOKEN_W'(1);
		end else if (token_limit > TOKEN_W'(MAX_TOKENS)) begin
			tl_eff = TOKEN_W'(MAX_TOKENS);
		end else begin
			tl_eff = token_limit;
		end
		ll_eff   = (line_limit > BYTES_W'(LINE_MAX)) ? BYTES_W'(LINE_MAX) : line_limit;
		tok_m1   = st.tokens - TOKEN_W'(1);
		idx_cur  = tok_m1[INDEX_W-1:0];
		at_limit = (st.tokens >= tl_eff);
		end_mode = at_limit ? M_SKIP : M_BETWEEN;
		end_err  = at_limit ? ST_MANY : st.err;
	end

	always_comb begin
		nxt = st;
		res = '0;
		if (ch == CH_NUL) begin
			case (st.mode)
				M_WORD, M_QBODY, M_QESC: begin
					res.char_valid  = 1'b1;
					res.token_index = idx_cur;
				end
				M_QSTART, M_QESC_START: begin
					res.char_valid  = 1'b1;
					res.token_start = 1'b1;
					res.token_index = idx_cur;
				end
				default: ;
			endcase
			res.line_done = 1'b1;
			if (st.bytes >= ll_eff) begin
				res.status = ST_LONG;
			end else if (st.err != ST_OK) begin
				res.status = ST_MANY;
			end else begin
				res.token_count = st.tokens;
			end
			nxt.mode   = M_BETWEEN;
			nxt.tokens = '0;
			nxt.bytes  = '0;
			nxt.err    = ST_OK;
		end else begin
			if (st.bytes < BYTES_W'(LINE_MAX)) begin
				nxt.bytes = st.bytes + BYTES_W'(1);
			end
			case (st.mode)
				M_WORD: begin
					res.char_valid  = 1'b1;
					res.token_index = idx_cur;
					if (blank) begin
						nxt.mode = end_mode;
						nxt.err  = end_err;
					end else begin
						res.out_char = ch;
					end
				end
				M_QSTART: begin
					if (ch == CH_BSL) begin
						nxt.mode = M_QESC_START;
					end else if (ch == CH_QUOTE) begin
						res.char_valid  = 1'b1;
						res.token_start = 1'b1;
						res.token_index = idx_cur;
						nxt.mode        = end_mode;
						nxt.err         = end_err;
					end else begin
						res.char_valid  = 1'b1;
						res.out_char    = ch;
						res.token_start = 1'b1;
						res.token_index = idx_cur;
						nxt.mode        = M_QBODY;
					end
				end
				M_QBODY: begin
					if (ch == CH_BSL) begin
						nxt.mode = M_QESC;
					end else if (ch == CH_QUOTE) begin
						res.char_valid  = 1'b1;
						res.token_index = idx_cur;
						nxt.mode        = end_mode;
						nxt.err         = end_err;
					end else begin
						res.char_valid  = 1'b1;
						res.out_char    = ch;
						res.token_index = idx_cur;
					end
				end
				M_QESC_START: begin
					res.char_valid  = 1'b1;
					res.out_char    = ch;
					res.token_start = 1'b1;
					res.token_index = idx_cur;
					nxt.mode        = M_QBODY;
				end
				M_QESC: begin
					res.char_valid  = 1'b1;
					res.out_char    = ch;
					res.token_index = idx_cur;
					nxt.mode        = M_QBODY;
				end
				M_SKIP: ;
				default: begin
					if (blank) begin
						nxt.mode = M_BETWEEN;
					end else if (ch == CH_QUOTE) begin
						nxt.tokens = st.tokens + TOKEN_W'(1);
						nxt.mode   = M_QSTART;
					end else begin
						nxt.tokens      = st.tokens + TOKEN_W'(1);
						res.char_valid  = 1'b1;
						res.out_char    = ch;
						res.token_start = 1'b1;
						res.token_index = st.tokens[INDEX_W-1:0];
						nxt.mode        = M_WORD;
					end
				end
			endcase
		end
	end

endmodule

/* tb/tb_quoted_token_splitter_unit.sv */
`timescale 1ns / 100ps

module tb_quoted_token_splitter_unit;
	import qts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	quoted_token_splitter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	logic [7:0] bytes_to_send[$];
	result_t    split_due[$];

	logic [TOKEN_W-1:0] tok_limit = 6'd32;
	logic [BYTES_W-1:0] ln_limit = 9'd256;
	mode_t              scan = M_BETWEEN;
	int                 toks = 0;
	int                 nbytes = 0;
	status_t            fault = ST_OK;

	int mismatches = 0;
	int results_seen = 0;
	int bytes_accepted = 0;
	int settings = 0;
	int lines_ok = 0;
	int lines_long = 0;
	int lines_full = 0;
	int cycles = 0;
	int holds_asked = 0;

	function automatic result_t token_byte(input logic [7:0] c, input logic first);
		result_t r;
		r = '0;
		r.char_valid = 1'b1;
		r.out_char = c;
		r.token_start = first;
		r.token_index = INDEX_W'(toks - 1);
		return r;
	endfunction

	function automatic void close_token();
		int lim;
		lim = (tok_limit == 0) ? 1 : ((tok_limit > MAX_TOKENS) ? MAX_TOKENS : int'(tok_limit));
		scan = M_BETWEEN;
		if (toks >= lim) begin
			fault = ST_MANY;
			scan = M_SKIP;
		end
	endfunction

	function automatic result_t split_byte(input logic [7:0] c);
		result_t r;
		logic    blank;
		int      lim;
		r = '0;
		blank = (c == CH_SPACE) || (c == CH_TAB);
		if (c == CH_NUL) begin
			lim = (ln_limit > LINE_MAX) ? LINE_MAX : int'(ln_limit);
			if (scan == M_WORD || scan == M_QBODY || scan == M_QESC)
				r = token_byte(CH_NUL, 1'b0);
			else if (scan == M_QSTART || scan == M_QESC_START)
				r = token_byte(CH_NUL, 1'b1);
			r.line_done = 1'b1;
			if (nbytes >= lim) begin
				r.status = ST_LONG;
				lines_long++;
			end else if (fault != ST_OK) begin
				r.status = ST_MANY;
				lines_full++;
			end else begin
				r.token_count = TOKEN_W'(toks);
				lines_ok++;
			end
			scan = M_BETWEEN;
			toks = 0;
			nbytes = 0;
			fault = ST_OK;
			return r;
		end
		if (nbytes < LINE_MAX)
			nbytes++;
		case (scan)
		M_WORD: begin
			if (blank) begin
				r = token_byte(CH_NUL, 1'b0);
				close_token();
			end else
				r = token_byte(c, 1'b0);
		end
		M_QSTART: begin
			if (c == CH_BSL)
				scan = M_QESC_START;
			else if (c == CH_QUOTE) begin
				r = token_byte(CH_NUL, 1'b1);
				close_token();
			end else begin
				r = token_byte(c, 1'b1);
				scan = M_QBODY;
			end
		end
		M_QBODY: begin
			if (c == CH_BSL)
				scan = M_QESC;
			else if (c == CH_QUOTE) begin
				r = token_byte(CH_NUL, 1'b0);
				close_token();
			end else
				r = token_byte(c, 1'b0);
		end
		M_QESC_START: begin
			r = token_byte(c, 1'b1);
			scan = M_QBODY;
		end
		M_QESC: begin
			r = token_byte(c, 1'b0);
			scan = M_QBODY;
		end
		M_SKIP: ;
		default: begin
			if (blank)
				scan = M_BETWEEN;
			else if (c == CH_QUOTE) begin
				toks++;
				scan = M_QSTART;
			end else begin
				toks++;
				r = token_byte(c, 1'b1);
				scan = M_WORD;
			end
		end
		endcase
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("valid %0b char %02h start %0b index %0d done %0b count %0d status %0d",
			r.char_valid, r.out_char, r.token_start, r.token_index, r.line_done,
			r.token_count, r.status);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endtask

	// sender: bursts of random length, random gaps in between
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				split_due.push_back(split_byte(s_axis_tdata));
				bytes_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left == 0 && bytes_to_send.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= bytes_to_send.pop_front();
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall styles, plus long hold-offs on request
	int         hold_left = 0;
	int         holds_given = 0;
	int         stall_style = 0;
	int         style_left = 0;
	logic [7:0] stall_pattern = 8'hff;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (holds_given != holds_asked && m_axis_tvalid) begin
			holds_given++;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(16, 96);
				stall_pattern = 8'($urandom);
			end else
				style_left--;
			case (stall_style)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: begin
				stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
				m_axis_tready <= stall_pattern[0];
			end
			endcase
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got.char_valid = m_axis_tdata[0];
			got.out_char = m_axis_tdata[8:1];
			got.token_start = m_axis_tdata[9];
			got.token_index = m_axis_tdata[14:10];
			got.line_done = m_axis_tlast;
			got.token_count = m_axis_tdata[20:15];
			got.status = status_t'(m_axis_tdata[22:21]);
			if (split_due.size() == 0)
				report_mismatch($sformatf("result %0d with no request pending: %s",
					results_seen, describe(got)));
			else begin
				want = split_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf("result %0d\n  expected %s\n  actual   %s",
						results_seen, describe(want), describe(got)));
			end
		end
	end

	task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
	                          output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_limits(input bit do_write, input int tok, input int ln);
		logic [31:0] wd;
		logic [31:0] rd;
		if (do_write) begin
			wd = $urandom;
			wd[5:0] = tok[5:0];
			reg_access(1'b1, ADDR_TOKEN_LIMIT, wd, rd);
			tok_limit = wd[5:0];
			wd = $urandom;
			wd[8:0] = ln[8:0];
			reg_access(1'b1, ADDR_LINE_LIMIT, wd, rd);
			ln_limit = wd[8:0];
		end
		reg_access(1'b0, ADDR_TOKEN_LIMIT, '0, rd);
		if (rd !== {26'd0, tok_limit})
			report_mismatch($sformatf("token_limit read %0h, expected %0h", rd, tok_limit));
		reg_access(1'b0, ADDR_LINE_LIMIT, '0, rd);
		if (rd !== {23'd0, ln_limit})
			report_mismatch($sformatf("line_limit read %0h, expected %0h", rd, ln_limit));
		settings++;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (bytes_to_send.size() != 0 || s_axis_tvalid || split_due.size() != 0);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			bytes_to_send.push_back(s[i]);
		bytes_to_send.push_back(CH_NUL);
	endtask

	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 9) < 7)
			return 8'(8'h61 + $urandom_range(0, 25));
		return 8'($urandom_range(1, 255));
	endfunction

	// mostly well-formed lines of words and quoted strings, some noise and broken endings
	task automatic queue_lines(input int count, input int long_pct);
		int queued;
		int target;
		int n;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(1, 100) <= long_pct)
				target = $urandom_range(60, 300);
			else
				target = $urandom_range(0, 16);
			n = 0;
			while (n < target) begin
				case ($urandom_range(0, 9))
				0, 1: begin
					bytes_to_send.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
					n++;
				end
				2, 3, 4: begin
					repeat ($urandom_range(1, 5)) begin
						bytes_to_send.push_back(text_byte());
						n++;
					end
					bytes_to_send.push_back(CH_SPACE);
					n++;
				end
				5, 6, 7, 8: begin
					bytes_to_send.push_back(CH_QUOTE);
					n++;
					repeat ($urandom_range(0, 4)) begin
						if ($urandom_range(0, 3) == 0) begin
							bytes_to_send.push_back(CH_BSL);
							n++;
						end
						bytes_to_send.push_back(text_byte());
						n++;
					end
					if ($urandom_range(0, 9) != 0) begin
						bytes_to_send.push_back(CH_QUOTE);
						n++;
					end
				end
				default: begin
					bytes_to_send.push_back(8'($urandom_range(1, 255)));
					n++;
				end
				endcase
			end
			case ($urandom_range(0, 9))
			0: begin
				bytes_to_send.push_back(CH_BSL);
				n++;
			end
			1: begin
				bytes_to_send.push_back(CH_QUOTE);
				n++;
			end
			default: ;
			endcase
			bytes_to_send.push_back(CH_NUL);
			queued += n + 1;
		end
	endtask

	task automatic run_phase(input int tok, input int ln, input int count, input int long_pct);
		program_limits(1'b1, tok, ln);
		queue_lines(count, long_pct);
		wait_idle();
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles, %0d results outstanding", cycles, split_due.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		program_limits(1'b0, 0, 0);

		queue_text("\"\" \"a\\\"b\"c");
		queue_text("\tx\"\\ \"\\");
		queue_text("\377 \"\001");
		queue_text("");
		holds_asked <= holds_asked + 1;
		queue_lines(200, 3);
		wait_idle();

		run_phase(1, 1, 90, 0);
		run_phase(3, 12, 110, 0);
		run_phase(0, 0, 60, 0);
		run_phase(63, 511, 150, 5);
		run_phase(7, 40, 80, 2);
		run_phase(32, 256, 110, 4);

		repeat (8) @(posedge clk);
		$display("Checked %0d results from %0d bytes under %0d limit settings, %0d mismatches.",
			results_seen, bytes_accepted, settings, mismatches);
		$display("Lines reported: %0d counted, %0d too long, %0d over the token limit.",
			lines_ok, lines_long, lines_full);
		if (mismatches == 0 && split_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
